### design/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types, register map and constants of the scalar Kalman filter.
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned GainW    = 25;
  localparam int unsigned FracW    = 24;
  localparam int unsigned DivSteps = GainW;
  localparam int unsigned CntW     = $clog2(DivSteps);
  localparam int unsigned AddrW    = 4;

  // Register indexes (byte address bits [3:2]).
  localparam logic [1:0] RegProcessNoise     = 2'd0;
  localparam logic [1:0] RegMeasurementNoise = 2'd1;
  localparam logic [1:0] RegStartError       = 2'd2;

  localparam logic [DataW-1:0] ProcessNoiseRst     = 32'd1678;
  localparam logic [DataW-1:0] MeasurementNoiseRst = 32'd8388608;
  localparam logic [DataW-1:0] StartErrorRst       = 32'd167772;

  localparam logic [GainW-1:0] GainOne = GainW'(1) << FracW;

  typedef struct packed {
    logic signed [DataW-1:0] sample;
    logic                    restart;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] smoothed;
    logic        [DataW-1:0] variance;
    logic        [GainW-1:0] gain;
  } out_t;

  typedef struct packed {
    logic load;
    logic pred;
    logic denom;
    logic div_step;
    logic mul_est;
    logic mul_var;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [DataW-1:0] process_noise;
    logic [DataW-1:0] measurement_noise;
    logic [DataW-1:0] start_error;
  } cfg_t;

endpackage

### design/scalar_kalman_filter_top.sv
// A request runs through prediction, the denominator, the 25-step serial
// gain divider, the two multiplies and the finish step before a new one is
// taken. A finished result waits in the output register while the next
// request is taken. Reset (rst_ni low, asynchronous) clears the estimate
// and variance to zero and loads the register reset values.
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top
// One-dimensional Kalman smoother with an APB register port.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [skf_pkg::AddrW-1:0]    paddr,
  input  logic [skf_pkg::DataW-1:0]    pwdata,
  output logic [skf_pkg::DataW-1:0]    prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  skf_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output skf_pkg::out_t                out_data_o
);

  skf_pkg::cfg_t cfg_q;
  skf_pkg::cmd_t cmd;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.process_noise     <= skf_pkg::ProcessNoiseRst;
      cfg_q.measurement_noise <= skf_pkg::MeasurementNoiseRst;
      cfg_q.start_error       <= skf_pkg::StartErrorRst;
    end else if (wr_en) begin
      case (paddr[3:2])
        skf_pkg::RegProcessNoise:     cfg_q.process_noise     <= pwdata;
        skf_pkg::RegMeasurementNoise: cfg_q.measurement_noise <= pwdata;
        skf_pkg::RegStartError:       cfg_q.start_error       <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      skf_pkg::RegProcessNoise:     prdata = cfg_q.process_noise;
      skf_pkg::RegMeasurementNoise: prdata = cfg_q.measurement_noise;
      skf_pkg::RegStartError:       prdata = cfg_q.start_error;
      default:                      prdata = '0;
    endcase
  end

  skf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  skf_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_i      (cfg_q),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

  // The gain never exceeds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.gain <= skf_pkg::GainOne))
    else $error("gain above one");

  // Only one request is in work at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while busy");

  // A result is loaded into the output register only when it is free or being emptied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.finish && out_valid_o) |-> out_ready_i)
    else $error("output register overwritten");

endmodule

### design/skf_ctrl.sv
// ----------------------------------------------------------------------------
// skf_ctrl
// Sequencer of the filter: input handshake, divider step count and output
// register handshake.
// ----------------------------------------------------------------------------
module skf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output skf_pkg::cmd_t cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StPred   = 3'd1;
  localparam logic [2:0] StDenom  = 3'd2;
  localparam logic [2:0] StDiv    = 3'd3;
  localparam logic [2:0] StMulEst = 3'd4;
  localparam logic [2:0] StMulVar = 3'd5;
  localparam logic [2:0] StFinish = 3'd6;

  logic [2:0]               state_q, state_d;
  logic [skf_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                     out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StPred;
        end
      end
      StPred: begin
        cmd_o.pred = 1'b1;
        state_d    = StDenom;
      end
      StDenom: begin
        cmd_o.denom = 1'b1;
        cnt_d       = skf_pkg::CntW'(skf_pkg::DivSteps - 1);
        state_d     = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = StMulEst;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StMulEst: begin
        cmd_o.mul_est = 1'b1;
        state_d       = StMulVar;
      end
      StMulVar: begin
        cmd_o.mul_var = 1'b1;
        state_d       = StFinish;
      end
      StFinish: begin
        // Wait until the output register is free or being emptied.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

### design/skf_dp.sv
// ----------------------------------------------------------------------------
// skf_dp
// Filter datapath: state registers, serial gain divider, shared multiplier
// and the output register.
// ----------------------------------------------------------------------------
module skf_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  skf_pkg::cmd_t cmd_i,
  input  skf_pkg::cfg_t cfg_i,
  input  skf_pkg::in_t  in_data_i,
  output skf_pkg::out_t out_data_o
);

  localparam int unsigned DW = skf_pkg::DataW;
  localparam int unsigned GW = skf_pkg::GainW;
  localparam int unsigned FW = skf_pkg::FracW;
  localparam int unsigned AW = DW + 2;         // multiplier operand a
  localparam int unsigned BW = GW + 1;         // multiplier operand b
  localparam int unsigned PW = AW + BW;        // product
  localparam int unsigned SW = PW - FW + 1;    // estimate sum

  localparam logic signed [PW-1:0] HalfP  = PW'(1) << (FW - 1);
  localparam logic signed [SW-1:0] EstMax = SW'((64'd1 << (DW - 1)) - 64'd1);
  localparam logic signed [SW-1:0] EstMin = -(SW'(1) << (DW - 1));

  logic signed [DW-1:0] sample_q;
  logic signed [DW-1:0] est_q;
  logic        [DW-1:0] var_q;
  logic        [DW-1:0] pred_q;
  logic        [DW:0]   denom_q;
  logic                 dzero_q;
  logic        [DW+1:0] rem_q;
  logic                 first_q;
  logic        [GW-1:0] quo_q;
  logic signed [PW-1:0] prod_q;
  skf_pkg::out_t        out_q;

  logic        [DW:0]   pred_sum;
  logic        [DW:0]   denom_sum;
  logic        [DW+1:0] rem_shift;
  logic        [GW-1:0] gain_w;
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] mul_p;
  logic signed [PW-1:0] est_round;
  logic signed [SW-1:0] est_sum;
  logic signed [DW-1:0] est_sat;
  logic        [PW-1:0] var_round;

  assign pred_sum  = {1'b0, var_q} + {1'b0, cfg_i.process_noise};
  assign denom_sum = {1'b0, pred_q} + {1'b0, cfg_i.measurement_noise};
  // The first divider step shifts in the low bit of the predicted variance.
  assign rem_shift = {rem_q[DW:0], first_q & pred_q[0]};
  assign gain_w    = dzero_q ? '0 : quo_q;

  always_comb begin
    if (cmd_i.mul_var) begin
      mul_a = $signed({2'b00, pred_q});
      mul_b = $signed({1'b0, skf_pkg::GainOne - gain_w});
    end else begin
      mul_a = AW'(sample_q) - AW'(est_q);
      mul_b = $signed({1'b0, gain_w});
    end
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // Round to nearest with ties upward: add one half, then shift arithmetically.
  assign est_round = prod_q + HalfP;
  assign est_sum   = SW'(est_q) + SW'($signed(est_round[PW-1:FW]));

  always_comb begin
    if (est_sum > EstMax) begin
      est_sat = DW'(EstMax);
    end else if (est_sum < EstMin) begin
      est_sat = DW'(EstMin);
    end else begin
      est_sat = est_sum[DW-1:0];
    end
  end

  assign var_round = prod_q + HalfP;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q <= '0;
      var_q <= '0;
    end else begin
      if (cmd_i.load && in_data_i.restart) begin
        est_q <= in_data_i.sample;
        var_q <= cfg_i.start_error;
      end else if (cmd_i.mul_var) begin
        est_q <= est_sat;
      end else if (cmd_i.finish) begin
        var_q <= var_round[FW+DW-1:FW];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= in_data_i.sample;
    end
    if (cmd_i.pred) begin
      pred_q <= pred_sum[DW] ? '1 : pred_sum[DW-1:0];
    end
    if (cmd_i.denom) begin
      denom_q <= denom_sum;
      dzero_q <= (denom_sum == '0);
      rem_q   <= {3'b000, pred_q[DW-1:1]};
      first_q <= 1'b1;
      quo_q   <= '0;
    end
    if (cmd_i.div_step) begin
      first_q <= 1'b0;
      if (rem_shift >= {1'b0, denom_q}) begin
        rem_q <= rem_shift - {1'b0, denom_q};
        quo_q <= {quo_q[GW-2:0], 1'b1};
      end else begin
        rem_q <= rem_shift;
        quo_q <= {quo_q[GW-2:0], 1'b0};
      end
    end
    if (cmd_i.mul_est || cmd_i.mul_var) begin
      prod_q <= mul_p;
    end
    if (cmd_i.finish) begin
      out_q.smoothed <= est_q;
      out_q.variance <= var_round[FW+DW-1:FW];
      out_q.gain     <= gain_w;
    end
  end

  assign out_data_o = out_q;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the scalar Kalman filter. A short table of directed
// samples covers the reset state, zero and saturated noise settings and the
// sample extremes. Random phases then run under different noise settings.
// Each result is checked against the bit-exact bench model or a fixed row value.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] RegUnused     = 2'd3;
  localparam int         IdleTail      = 40;
  localparam int         NumPhases     = 7;
  localparam int         PhaseItems    = 250;
  localparam int         TimeoutCycles = 400000;

  typedef enum logic {RowItem, RowCfg} row_kind_e;

  typedef struct {
    row_kind_e     kind;
    skf_pkg::in_t  item;
    bit            fixed;
    skf_pkg::out_t result;
    skf_pkg::cfg_t cfg;
  } plan_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [skf_pkg::AddrW-1:0] paddr;
  logic [skf_pkg::DataW-1:0] pwdata;
  logic [skf_pkg::DataW-1:0] prdata;
  logic                      pready;
  logic                      in_valid_i;
  logic                      in_ready_o;
  skf_pkg::in_t              in_data_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  skf_pkg::out_t             out_data_o;

  // Filter model state and its copy of the registers.
  skf_pkg::cfg_t                    filt_cfg;
  logic signed [skf_pkg::DataW-1:0] est_q;
  logic        [skf_pkg::DataW-1:0] var_q;

  skf_pkg::out_t pending_estimates[$];
  plan_row_t     stim_plan[$];
  bit            golden_armed;
  skf_pkg::out_t golden_result;
  bit            gap_on;
  bit            stall_on;
  int            stall_left;
  int unsigned   mismatch_count;
  int unsigned   cycle_count;

  scalar_kalman_filter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // One filter update: optional restart, predict, gain, correct.
  function automatic skf_pkg::out_t kalman_step(input skf_pkg::in_t item);
    logic [skf_pkg::DataW:0]   sum;
    logic [skf_pkg::DataW-1:0] pred;
    logic [skf_pkg::DataW:0]   denom;
    longint unsigned           numer;
    longint unsigned           vnum;
    longint                    gain;
    longint                    diff;
    longint                    t;
    longint                    next_est;
    skf_pkg::out_t             res;
    if (item.restart) begin
      est_q = item.sample;
      var_q = filt_cfg.start_error;
    end
    sum   = {1'b0, var_q} + {1'b0, filt_cfg.process_noise};
    pred  = sum[skf_pkg::DataW] ? '1 : sum[skf_pkg::DataW-1:0];
    denom = {1'b0, pred} + {1'b0, filt_cfg.measurement_noise};
    numer = 64'(pred) << skf_pkg::FracW;
    gain  = (denom == '0) ? 0 : longint'(numer / 64'(denom));
    diff  = longint'($signed(item.sample)) - longint'(est_q);
    // Adding one half before the arithmetic shift rounds ties upward.
    t        = diff * gain + (64'sd1 <<< (skf_pkg::FracW - 1));
    next_est = longint'(est_q) + (t >>> skf_pkg::FracW);
    if (next_est > 64'sd2147483647) begin
      est_q = 32'sh7FFF_FFFF;
    end else if (next_est < -64'sd2147483648) begin
      est_q = 32'sh8000_0000;
    end else begin
      est_q = next_est[skf_pkg::DataW-1:0];
    end
    vnum  = 64'(pred) * ((64'd1 << skf_pkg::FracW) - 64'(gain))
            + (64'd1 << (skf_pkg::FracW - 1));
    var_q = vnum[skf_pkg::FracW +: skf_pkg::DataW];
    res.smoothed = est_q;
    res.variance = var_q;
    res.gain     = gain[skf_pkg::GainW-1:0];
    return res;
  endfunction

  function automatic logic [skf_pkg::DataW-1:0] pick_noise();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return $urandom();
      3: return $urandom_range(0, 4096);
      default: return $urandom_range(0, 1 << skf_pkg::FracW);
    endcase
  endfunction

  function automatic void append_row(input plan_row_t row);
    stim_plan = {stim_plan, row};
  endfunction

  function automatic void add_item(input logic [skf_pkg::DataW-1:0] sample,
                                   input logic restart);
    append_row('{kind: RowItem, item: '{sample, restart}, fixed: 1'b0,
                 result: '0, cfg: '0});
  endfunction

  function automatic void add_fixed(input logic [skf_pkg::DataW-1:0] sample,
                                    input logic restart,
                                    input logic [skf_pkg::DataW-1:0] smoothed,
                                    input logic [skf_pkg::DataW-1:0] variance,
                                    input logic [skf_pkg::GainW-1:0] gain);
    append_row('{kind: RowItem, item: '{sample, restart}, fixed: 1'b1,
                 result: '{smoothed, variance, gain}, cfg: '0});
  endfunction

  function automatic void add_cfg(input logic [skf_pkg::DataW-1:0] q,
                                  input logic [skf_pkg::DataW-1:0] r,
                                  input logic [skf_pkg::DataW-1:0] se);
    append_row('{kind: RowCfg, item: '0, fixed: 1'b0, result: '0,
                 cfg: '{q, r, se}});
  endfunction

  task automatic apb_write(input logic [1:0] index,
                           input logic [skf_pkg::DataW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // A write to the unused slot must leave the filter untouched.
  task automatic load_filter_cfg(input skf_pkg::cfg_t c);
    apb_write(skf_pkg::RegProcessNoise, c.process_noise);
    apb_write(skf_pkg::RegMeasurementNoise, c.measurement_noise);
    apb_write(skf_pkg::RegStartError, c.start_error);
    apb_write(RegUnused, $urandom());
    filt_cfg = c;
  endtask

  task automatic push_sample(input skf_pkg::in_t item, input bit fixed,
                             input skf_pkg::out_t result);
    int n;
    if (gap_on && $urandom_range(0, 2) == 0) begin
      n = $urandom_range(1, 9);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    in_data_i     <= item;
    golden_armed  <= fixed;
    golden_result <= result;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop the request line and wait until the filter has handed back everything.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_estimates.size() != 0) @(negedge clk_i);
    repeat (IdleTail) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  = stall_left - 1;
    end else if (stall_on && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  = $urandom_range(1, 9) - 1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    skf_pkg::out_t want;
    skf_pkg::out_t got;
    if (rst_ni && in_valid_i && in_ready_o) begin
      want = kalman_step(in_data_i);
      if (golden_armed) begin
        want = golden_result;
      end
      pending_estimates = {pending_estimates, want};
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = out_data_o;
      if (pending_estimates.size() == 0) begin
        $display("%0t: unexpected result smoothed %0d variance %0d gain %0d", $time,
                 $signed(got.smoothed), got.variance, got.gain);
        mismatch_count++;
      end else begin
        want = pending_estimates.pop_front();
        if (got.smoothed !== want.smoothed) begin
          $display("%0t: smoothed expected %0d, got %0d", $time,
                   $signed(want.smoothed), $signed(got.smoothed));
          mismatch_count++;
        end
        if (got.variance !== want.variance) begin
          $display("%0t: variance expected %0d, got %0d", $time,
                   want.variance, got.variance);
          mismatch_count++;
        end
        if (got.gain !== want.gain) begin
          $display("%0t: gain expected %0d, got %0d", $time, want.gain, got.gain);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > TimeoutCycles) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    skf_pkg::in_t                     item;
    logic signed [skf_pkg::DataW-1:0] level;
    logic signed [skf_pkg::DataW-1:0] noise;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_ready_i    = 1'b0;
    golden_armed   = 1'b0;
    golden_result  = '0;
    gap_on         = 1'b1;
    stall_on       = 1'b1;
    stall_left     = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    filt_cfg       = '{skf_pkg::ProcessNoiseRst, skf_pkg::MeasurementNoiseRst,
                       skf_pkg::StartErrorRst};
    est_q          = '0;
    var_q          = '0;

    // Reset values first, with no restart so the filter runs from zero state.
    add_item(32'h0001_0000, 1'b0);
    add_item(32'hFFFF_0000, 1'b0);
    add_item(32'h1234_5678, 1'b1);
    add_item(32'h1234_0000, 1'b0);
    // Both variances zero: the gain is forced to zero and nothing moves.
    add_cfg('0, '0, '0);
    add_fixed(32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, '0, '0);
    add_fixed(32'h8000_0000, 1'b0, 32'h7FFF_FFFF, '0, '0);
    add_fixed(32'h0000_0000, 1'b0, 32'h7FFF_FFFF, '0, '0);
    // No measurement noise: full gain, the estimate jumps to the sample.
    add_cfg('1, '0, '1);
    add_fixed(32'h8000_0000, 1'b0, 32'h8000_0000, '0, skf_pkg::GainOne);
    add_fixed(32'h7FFF_FFFF, 1'b0, 32'h7FFF_FFFF, '0, skf_pkg::GainOne);
    add_fixed(32'h5A5A_5A5A, 1'b1, 32'h5A5A_5A5A, '0, skf_pkg::GainOne);
    // Everything saturated: the gain settles at one half.
    add_cfg('1, '1, '1);
    add_fixed(32'h8000_0000, 1'b1, 32'h8000_0000, 32'h8000_0000, skf_pkg::GainOne >> 1);
    add_fixed(32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, skf_pkg::GainOne >> 1);
    add_item(32'h0000_0000, 1'b0);
    add_cfg(32'd1, 32'd1, 32'd1);
    add_item(32'hFFFF_FFFF, 1'b1);
    add_item(32'h7FFF_0000, 1'b0);
    add_item(32'h8000_0001, 1'b0);
    add_cfg(32'd0, 32'h0100_0000, 32'h0001_0000);
    add_item(32'h0000_FFFF, 1'b1);
    add_item(32'hAAAA_5555, 1'b0);
    add_item(32'h5555_AAAA, 1'b0);

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_plan[i]) begin
      if (stim_plan[i].kind == RowCfg) begin
        settle();
        load_filter_cfg(stim_plan[i].cfg);
      end else begin
        push_sample(stim_plan[i].item, stim_plan[i].fixed, stim_plan[i].result);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      gap_on   = (ph != NumPhases - 1) && ($urandom_range(0, 3) != 0);
      stall_on = (ph != NumPhases - 1) && ($urandom_range(0, 3) != 0);
      if (ph == 0) begin
        load_filter_cfg('{skf_pkg::ProcessNoiseRst, skf_pkg::MeasurementNoiseRst,
                          skf_pkg::StartErrorRst});
      end else begin
        load_filter_cfg('{pick_noise(), pick_noise(), pick_noise()});
      end
      level = $urandom();
      for (int k = 0; k < PhaseItems; k++) begin
        item.restart = (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 24) == 0);
        case ($urandom_range(0, 9))
          0, 1: item.sample = $urandom();
          2: item.sample = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
          default: begin
            // A slowly wandering signal with measurement noise on top.
            level       = level + $signed($urandom_range(0, 1 << 17)) - (1 << 16);
            noise       = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            item.sample = level + noise;
          end
        endcase
        push_sample(item, 1'b0, '0);
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
design/skf_pkg.sv
design/skf_ctrl.sv
design/skf_dp.sv
design/scalar_kalman_filter_top.sv
tb/sv/tb_top.sv
